### rtl/binary_max_heap_queue_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the heap queue
// Shared clocking and reset gating for concurrent checks.
// ----------------------------------------------------------------------------
`ifndef BINARY_MAX_HEAP_QUEUE_MACROS_SVH
`define BINARY_MAX_HEAP_QUEUE_MACROS_SVH

// Check a property on every clock edge outside reset
`define HMQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle
`define HMQ_ASSERT_IMP(name, ante, cons, msg) \
  `HMQ_ASSERT(name, (ante) |-> (cons), msg)

// Check that a condition implies another in the next cycle
`define HMQ_ASSERT_NEXT(name, ante, cons, msg) \
  `HMQ_ASSERT(name, (ante) |=> (cons), msg)

`endif

### rtl/hmq_pkg.sv
// ----------------------------------------------------------------------------
// hmq_pkg
// Types, codes and constants shared by the heap queue controller and datapath.
// ----------------------------------------------------------------------------
package hmq_pkg;

  localparam int unsigned HMQ_CAPACITY = 1024;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned COUNT_W      = 11;

  // Key reported when nothing was removed or the heap is empty (1.0 in Q16.16)
  localparam logic signed [DATA_W-1:0] KEY_ONE      = 32'sh0001_0000;
  // Payload reported when the heap is empty
  localparam logic signed [DATA_W-1:0] PAYLOAD_NONE = '1;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  // Datapath commands
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_PUSH,
    CMD_DROP,
    CMD_POP,
    CMD_POP_EMPTY,
    CMD_POP_LOAD,
    CMD_UP_READ,
    CMD_UP_STEP,
    CMD_DN_READ,
    CMD_DN_STEP,
    CMD_PLACE,
    CMD_TOP_READ,
    CMD_TOP_LOAD
  } cmd_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    cmd_e cmd;
  } ctrl_t;

  typedef struct packed {
    logic full;     // fill count at capacity
    logic empty;    // fill count zero
    logic at_root;  // sift position is the root
    logic up_move;  // parent key strictly below the moving key
    logic dn_stop;  // no child key strictly above the moving key
  } stat_t;

endpackage

### rtl/hmq_ctrl.sv
// ----------------------------------------------------------------------------
// hmq_ctrl
// Sequencer for push, pop and result delivery of the heap queue.
// ----------------------------------------------------------------------------
`include "binary_max_heap_queue_macros.svh"

module hmq_ctrl import hmq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  logic  mode_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_UP_RD  = 8'b0000_0010,
    S_UP_CMP = 8'b0000_0100,
    S_POP_LD = 8'b0000_1000,
    S_DN_RD  = 8'b0001_0000,
    S_DN_CMP = 8'b0010_0000,
    S_TOP_RD = 8'b0100_0000,
    S_TOP_LD = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Sequence the operation and issue one datapath command a cycle
  always_comb begin
    state_d     = state_q;
    ctrl_o.cmd  = CMD_NONE;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (mode_i == OP_POP) begin
            if (stat_i.empty) begin
              ctrl_o.cmd = CMD_POP_EMPTY;
              state_d    = S_TOP_RD;
            end else begin
              ctrl_o.cmd = CMD_POP;
              state_d    = S_POP_LD;
            end
          end else begin
            if (stat_i.full) begin
              ctrl_o.cmd = CMD_DROP;
              state_d    = S_TOP_RD;
            end else begin
              ctrl_o.cmd = CMD_PUSH;
              state_d    = S_UP_RD;
            end
          end
        end
      end
      S_UP_RD: begin
        if (stat_i.at_root) begin
          ctrl_o.cmd = CMD_PLACE;
          state_d    = S_TOP_RD;
        end else begin
          ctrl_o.cmd = CMD_UP_READ;
          state_d    = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat_i.up_move) begin
          ctrl_o.cmd = CMD_UP_STEP;
          state_d    = S_UP_RD;
        end else begin
          ctrl_o.cmd = CMD_PLACE;
          state_d    = S_TOP_RD;
        end
      end
      S_POP_LD: begin
        ctrl_o.cmd = CMD_POP_LOAD;
        state_d    = S_DN_RD;
      end
      S_DN_RD: begin
        ctrl_o.cmd = CMD_DN_READ;
        state_d    = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (stat_i.dn_stop) begin
          ctrl_o.cmd = CMD_PLACE;
          state_d    = S_TOP_RD;
        end else begin
          ctrl_o.cmd = CMD_DN_STEP;
          state_d    = S_DN_RD;
        end
      end
      S_TOP_RD: begin
        ctrl_o.cmd = CMD_TOP_READ;
        state_d    = S_TOP_LD;
      end
      S_TOP_LD: begin
        // Load the result register once it is free, else keep reading the root
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.cmd  = CMD_TOP_LOAD;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          ctrl_o.cmd = CMD_TOP_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Advance state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  `HMQ_ASSERT_IMP(a_valid_from_load, $rose(out_valid_q), $past(state_q == S_TOP_LD), "result valid without root load")
  `HMQ_ASSERT_NEXT(a_accept_busy, in_valid_i && in_ready_o, !in_ready_o, "accepted beat did not start work")
  `HMQ_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result beat dropped before accept")

endmodule

### rtl/hmq_dpath.sv
// ----------------------------------------------------------------------------
// hmq_dpath
// Heap storage, sift position, fill count and result registers.
// ----------------------------------------------------------------------------
`include "binary_max_heap_queue_macros.svh"

module hmq_dpath import hmq_pkg::*; #(
  parameter int unsigned CAPACITY = HMQ_CAPACITY
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctrl_t                    ctrl_i,
  output stat_t                    stat_o,
  input  logic signed [DATA_W-1:0] key_in_i,
  input  logic signed [DATA_W-1:0] payload_in_i,
  output logic signed [DATA_W-1:0] popped_key_o,
  output logic signed [DATA_W-1:0] top_key_o,
  output logic signed [DATA_W-1:0] top_payload_o,
  output logic [COUNT_W-1:0]       entry_count_o,
  output logic                     is_empty_o,
  output logic                     push_dropped_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = CW + 1;

  entry_t mem [CAPACITY];

  logic [AW-1:0] rd_a_addr, rd_b_addr, wr_addr;
  logic          wr_en;
  entry_t        wr_data, rd_a_q, rd_b_q;

  logic [CW-1:0]            cnt_q, cnt_d, cnt_m1;
  logic [PW-1:0]            idx_q, idx_d;
  entry_t                   cur_q, cur_d;
  logic signed [DATA_W-1:0] pop_w_q, pop_w_d;
  logic                     drop_w_q, drop_w_d;

  logic signed [DATA_W-1:0] res_pop_q, res_key_q, res_pay_q;
  logic [COUNT_W-1:0]       res_cnt_q;
  logic                     res_empty_q, res_drop_q;
  logic [CW+COUNT_W-1:0]    cnt_wide;

  logic [PW-1:0] cnt_ext, idx_m1, parent, parent_m1, child_l, child_l_m1;
  logic          j_ok, r_ok, i_ok, left_better, sel_r;
  entry_t        child;

  // Storage: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_q <= mem[rd_a_addr];
    rd_b_q <= mem[rd_b_addr];
  end

  // Position arithmetic, one-based positions
  assign cnt_ext    = PW'(cnt_q);
  assign cnt_m1     = cnt_q - CW'(1);
  assign idx_m1     = idx_q - PW'(1);
  assign parent     = idx_q >> 1;
  assign parent_m1  = parent - PW'(1);
  assign child_l    = {idx_q[PW-2:0], 1'b0};
  assign child_l_m1 = child_l - PW'(1);
  assign j_ok       = (child_l <= cnt_ext);
  assign r_ok       = (child_l < cnt_ext);
  assign i_ok       = (idx_q <= cnt_ext);

  // Pick the larger child; left wins a tie
  assign left_better = j_ok && (rd_a_q.key > cur_q.key);
  assign sel_r       = r_ok && (rd_b_q.key > (left_better ? rd_a_q.key : cur_q.key));
  assign child       = sel_r ? rd_b_q : rd_a_q;

  assign stat_o.full    = (cnt_q == CW'(CAPACITY));
  assign stat_o.empty   = (cnt_q == '0);
  assign stat_o.at_root = (idx_q == PW'(1));
  assign stat_o.up_move = (rd_a_q.key < cur_q.key);
  assign stat_o.dn_stop = !left_better && !sel_r;

  // Decode commands into storage accesses and register updates
  always_comb begin
    rd_a_addr = '0;
    rd_b_addr = '0;
    wr_en     = 1'b0;
    wr_addr   = idx_m1[AW-1:0];
    wr_data   = cur_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    cur_d     = cur_q;
    pop_w_d   = pop_w_q;
    drop_w_d  = drop_w_q;
    case (ctrl_i.cmd)
      CMD_PUSH: begin
        cur_d    = '{key: key_in_i, payload: payload_in_i};
        idx_d    = cnt_ext + PW'(1);
        cnt_d    = cnt_q + CW'(1);
        pop_w_d  = KEY_ONE;
        drop_w_d = 1'b0;
      end
      CMD_DROP: begin
        pop_w_d  = KEY_ONE;
        drop_w_d = 1'b1;
      end
      CMD_POP_EMPTY: begin
        pop_w_d  = KEY_ONE;
        drop_w_d = 1'b0;
      end
      CMD_POP: begin
        rd_a_addr = '0;
        rd_b_addr = cnt_m1[AW-1:0];
        drop_w_d  = 1'b0;
      end
      CMD_POP_LOAD: begin
        pop_w_d = rd_a_q.key;
        cur_d   = rd_b_q;
        cnt_d   = cnt_m1;
        idx_d   = PW'(1);
      end
      CMD_UP_READ: begin
        rd_a_addr = parent_m1[AW-1:0];
      end
      CMD_UP_STEP: begin
        wr_en   = 1'b1;
        wr_data = rd_a_q;
        idx_d   = parent;
      end
      CMD_DN_READ: begin
        rd_a_addr = child_l_m1[AW-1:0];
        rd_b_addr = child_l[AW-1:0];
      end
      CMD_DN_STEP: begin
        wr_en   = 1'b1;
        wr_data = child;
        idx_d   = sel_r ? child_l + PW'(1) : child_l;
      end
      CMD_PLACE: begin
        wr_en = i_ok;
      end
      CMD_TOP_READ: begin
        rd_a_addr = '0;
      end
      default: begin
      end
    endcase
  end

  // Fill count, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Advance working registers
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    cur_q    <= cur_d;
    pop_w_q  <= pop_w_d;
    drop_w_q <= drop_w_d;
  end

  assign cnt_wide = (CW + COUNT_W)'(cnt_q);

  // Load the result register from the root read, the fill count and the working registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmd == CMD_TOP_LOAD) begin
      res_pop_q   <= pop_w_q;
      res_key_q   <= stat_o.empty ? KEY_ONE : rd_a_q.key;
      res_pay_q   <= stat_o.empty ? PAYLOAD_NONE : rd_a_q.payload;
      res_cnt_q   <= cnt_wide[COUNT_W-1:0];
      res_empty_q <= stat_o.empty;
      res_drop_q  <= drop_w_q;
    end
  end

  assign popped_key_o   = res_pop_q;
  assign top_key_o      = res_key_q;
  assign top_payload_o  = res_pay_q;
  assign entry_count_o  = res_cnt_q;
  assign is_empty_o     = res_empty_q;
  assign push_dropped_o = res_drop_q;

  `HMQ_ASSERT(a_cnt_bound, cnt_q <= CW'(CAPACITY), "fill count above capacity")
  `HMQ_ASSERT_NEXT(a_up_ascends, ctrl_i.cmd == CMD_UP_STEP, idx_q < $past(idx_q), "sift up did not move toward root")
  `HMQ_ASSERT_NEXT(a_dn_descends, ctrl_i.cmd == CMD_DN_STEP, idx_q > $past(idx_q), "sift down did not move toward leaves")

endmodule

### rtl/binary_max_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_max_heap_queue
// Max-priority queue of (key, payload) entries held as a binary heap.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries one operation per beat:
// mode_i selects push of key_in_i/payload_in_i or pop of the largest key.
// Output channel (out_valid_o/out_ready_i) returns one beat per operation
// with the removed key, the root entry after the step, the entry count,
// an empty flag and a flag for a push refused because the heap was full.
// Keys compare as signed Q16.16; between equal children the left one moves up.
// Steps: a push reads each parent and moves it down while it is strictly
// smaller, then places the new entry; a pop loads the last entry at the
// root and sifts it down; a refused push or an empty pop does neither.
// Each level costs one registered read of the heap memory and one compare
// and write; each operation ends by loading the result from the root.
// One operation is in flight at a time; in_ready_o is high when idle.
// Reset empties the heap at once: only the fill count is cleared, no sweep.
// The result sits in an output register; while the receiver stalls the
// block still accepts the next operation and holds its result back until
// the register frees.
// ----------------------------------------------------------------------------
module binary_max_heap_queue import hmq_pkg::*; #(
  parameter int unsigned CAPACITY = HMQ_CAPACITY
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     mode_i,
  input  logic signed [DATA_W-1:0] key_in_i,
  input  logic signed [DATA_W-1:0] payload_in_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] popped_key_o,
  output logic signed [DATA_W-1:0] top_key_o,
  output logic signed [DATA_W-1:0] top_payload_o,
  output logic [COUNT_W-1:0]       entry_count_o,
  output logic                     is_empty_o,
  output logic                     push_dropped_o
);

  ctrl_t ctrl;
  stat_t stat;

  // Sequencer
  hmq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  // Storage and result path
  hmq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .key_in_i       (key_in_i),
    .payload_in_i   (payload_in_i),
    .popped_key_o   (popped_key_o),
    .top_key_o      (top_key_o),
    .top_payload_o  (top_payload_o),
    .entry_count_o  (entry_count_o),
    .is_empty_o     (is_empty_o),
    .push_dropped_o (push_dropped_o)
  );

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap queue testbench
// Feeds push and pop beats into the max-heap queue, including a fill to full
// capacity and drains to empty. A local heap predicts every result beat, and
// each result is checked field by field against that prediction.
// ----------------------------------------------------------------------------
module testbench;
  import hmq_pkg::*;

  localparam int unsigned CAP         = HMQ_CAPACITY;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned IDLE_PCT    = 27;
  localparam int unsigned CALM_START  = 3000;
  localparam int unsigned CALM_END    = 6000;
  localparam int unsigned HOLD_START  = 9000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 40;

  typedef struct packed {
    op_e                      op;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] payload;
  } heap_op_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_key;
    logic signed [DATA_W-1:0] top_key;
    logic signed [DATA_W-1:0] top_payload;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_empty;
    logic                     push_dropped;
  } heap_report_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                     in_valid   = 1'b0;
  logic                     mode_d     = OP_PUSH;
  logic signed [DATA_W-1:0] key_d      = '0;
  logic signed [DATA_W-1:0] payload_d  = '0;
  logic                     out_ready  = 1'b0;

  logic                     in_ready_o;
  logic                     out_valid_o;
  logic signed [DATA_W-1:0] popped_key_o;
  logic signed [DATA_W-1:0] top_key_o;
  logic signed [DATA_W-1:0] top_payload_o;
  logic [COUNT_W-1:0]       entry_count_o;
  logic                     is_empty_o;
  logic                     push_dropped_o;

  binary_max_heap_queue u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_d),
    .key_in_i      (key_d),
    .payload_in_i  (payload_d),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .popped_key_o  (popped_key_o),
    .top_key_o     (top_key_o),
    .top_payload_o (top_payload_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o),
    .push_dropped_o(push_dropped_o)
  );

  // Stimulus and prediction stores
  heap_op_t     op_queue[$];
  heap_report_t predicted_reports[$];
  int unsigned  gen_fill;

  // Local heap, one-based
  logic signed [DATA_W-1:0] heap_keys     [1:CAP];
  logic signed [DATA_W-1:0] heap_payloads [1:CAP];
  int unsigned              heap_fill = 0;

  int unsigned cycle_count  = 0;
  int unsigned err_count    = 0;
  int unsigned results_seen = 0;
  int unsigned n_push = 0, n_drop = 0, n_pop = 0, n_pop_empty = 0, peak_fill = 0;

  // Apply one operation to the local heap and return the report it yields
  function automatic heap_report_t step_heap(op_e op, logic signed [DATA_W-1:0] key,
                                             logic signed [DATA_W-1:0] pay);
    heap_report_t             rep;
    logic signed [DATA_W-1:0] last_key, last_pay, best;
    int unsigned              i, j, k, n;
    rep.popped_key   = KEY_ONE;
    rep.push_dropped = 1'b0;
    if (op == OP_PUSH) begin
      n_push++;
      if (heap_fill >= CAP) begin
        rep.push_dropped = 1'b1;
        n_drop++;
      end else begin
        // Sift up past strictly smaller parents
        i = heap_fill + 1;
        while (i > 1 && heap_keys[i/2] < key) begin
          heap_keys[i]     = heap_keys[i/2];
          heap_payloads[i] = heap_payloads[i/2];
          i = i / 2;
        end
        heap_keys[i]     = key;
        heap_payloads[i] = pay;
        heap_fill++;
      end
    end else begin
      n_pop++;
      if (heap_fill == 0) begin
        n_pop_empty++;
      end else begin
        rep.popped_key = heap_keys[1];
        last_key       = heap_keys[heap_fill];
        last_pay       = heap_payloads[heap_fill];
        n              = heap_fill - 1;
        heap_fill      = n;
        i              = 1;
        // Sift the last entry down; left child wins a tie
        forever begin
          j    = 2 * i;
          k    = 0;
          best = last_key;
          if (j <= n && heap_keys[j] > best) begin
            k    = j;
            best = heap_keys[j];
          end
          if (j + 1 <= n && heap_keys[j+1] > best) k = j + 1;
          if (k == 0) begin
            if (i <= n) begin
              heap_keys[i]     = last_key;
              heap_payloads[i] = last_pay;
            end
            break;
          end
          heap_keys[i]     = heap_keys[k];
          heap_payloads[i] = heap_payloads[k];
          i = k;
        end
      end
    end
    if (heap_fill > peak_fill) peak_fill = heap_fill;
    rep.is_empty    = (heap_fill == 0);
    rep.top_key     = rep.is_empty ? KEY_ONE : heap_keys[1];
    rep.top_payload = rep.is_empty ? PAYLOAD_NONE : heap_payloads[1];
    rep.entry_count = heap_fill[COUNT_W-1:0];
    return rep;
  endfunction

  // Queue one operation and track the fill it leads to
  task automatic add_op(op_e op, logic signed [DATA_W-1:0] key,
                        logic signed [DATA_W-1:0] pay);
    heap_op_t item;
    item.op      = op;
    item.key     = key;
    item.payload = pay;
    op_queue.push_back(item);
    if (op == OP_PUSH && gen_fill < CAP) gen_fill++;
    else if (op == OP_POP && gen_fill > 0) gen_fill--;
  endtask

  // Keys: wide random, tie-heavy small set, extremes, small signed values
  function automatic logic signed [DATA_W-1:0] rand_key();
    logic signed [DATA_W-1:0] k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: k = $urandom;
      4, 5:       k = ($signed($urandom_range(0, 4)) - 2) <<< 16;
      6: begin
        case ($urandom_range(0, 4))
          0:       k = 32'sh7FFF_FFFF;
          1:       k = 32'sh8000_0000;
          2:       k = '0;
          3:       k = KEY_ONE;
          default: k = '1;
        endcase
      end
      default:    k = $signed($urandom_range(0, 4095)) - 2048;
    endcase
    return k;
  endfunction

  task automatic add_random(int unsigned push_pct);
    if ($urandom_range(0, 99) < push_pct) add_op(OP_PUSH, rand_key(), $urandom);
    else add_op(OP_POP, $urandom, $urandom);
  endtask

  function automatic bit calm();
    return cycle_count >= CALM_START && cycle_count < CALM_END;
  endfunction

  // Clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Driver: offer queued operations, predict on each accepted beat
  always @(posedge clk_i or negedge rst_ni) begin
    heap_op_t item;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o)
        predicted_reports.push_back(step_heap(op_e'(mode_d), key_d, payload_d));
      if (!in_valid || in_ready_o) begin
        if (op_queue.size() > 0 && (calm() || $urandom_range(0, 99) >= IDLE_PCT)) begin
          item = op_queue.pop_front();
          in_valid  <= 1'b1;
          mode_d    <= item.op;
          key_d     <= item.key;
          payload_d <= item.payload;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      err_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  // Hold off the receiver once for a long stretch
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && cycle_count >= HOLD_START) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: check result beats, randomize ready outside the hold
  always @(posedge clk_i or negedge rst_ni) begin
    heap_report_t exp_rep;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        results_seen++;
        if (predicted_reports.size() == 0) begin
          err_count++;
          $display("%0t: result beat with nothing expected, actual count %0d",
                   $time, entry_count_o);
        end else begin
          exp_rep = predicted_reports.pop_front();
          check_field("popped_key", exp_rep.popped_key, popped_key_o);
          check_field("top_key", exp_rep.top_key, top_key_o);
          check_field("top_payload", exp_rep.top_payload, top_payload_o);
          check_field("entry_count", DATA_W'(exp_rep.entry_count), DATA_W'(entry_count_o));
          check_field("is_empty", DATA_W'(exp_rep.is_empty), DATA_W'(is_empty_o));
          check_field("push_dropped", DATA_W'(exp_rep.push_dropped),
                      DATA_W'(push_dropped_o));
        end
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm() || $urandom_range(0, 99) >= IDLE_PCT;
      end
    end
  end

  // Timeout
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("testbench NOT OK");
    $finish;
  end

  // Stimulus, reset and end of run
  initial begin
    gen_fill = 0;

    // Directed: empty pop, key extremes, ties on the root and below, drain past empty
    add_op(OP_POP,  32'sh1234_5678, 32'sh0BAD_F00D);
    add_op(OP_PUSH, 32'sh7FFF_FFFF, 32'sh0000_0000);
    add_op(OP_PUSH, 32'sh8000_0000, 32'shFFFF_FFFF);
    add_op(OP_PUSH, KEY_ONE,        32'sh1234_5678);
    add_op(OP_PUSH, 32'sh0000_0000, 32'sh8000_0000);
    add_op(OP_PUSH, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    add_op(OP_PUSH, 32'sh0005_0000, 32'sh0000_0001);
    add_op(OP_PUSH, 32'sh0005_0000, 32'sh0000_0002);
    add_op(OP_PUSH, 32'sh0005_0000, 32'sh0000_0003);
    add_op(OP_PUSH, 32'shFFFF_FFFF, 32'sh5555_5555);
    repeat (10) add_op(OP_POP, $urandom, $urandom);
    add_op(OP_PUSH, 32'sh8000_0000, 32'shAAAA_AAAA);
    add_op(OP_POP,  32'sh0000_0000, 32'sh0000_0000);

    // Random: mixed traffic near empty, then fill to capacity
    repeat (20) add_random(55);
    while (gen_fill < CAP) add_random(98);

    // Pushes into a full heap, one slot freed and refilled in between
    repeat (3) add_op(OP_PUSH, rand_key(), $urandom);
    add_op(OP_POP, $urandom, $urandom);
    repeat (3) add_op(OP_PUSH, rand_key(), $urandom);

    // Pop-heavy tail to walk the heap back down
    repeat (30) add_random(30);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (op_queue.size() != 0 || in_valid || predicted_reports.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (predicted_reports.size() != 0) begin
      err_count++;
      $display("%0t: %0d expected results never arrived", $time, predicted_reports.size());
    end
    $display("Covered %0d pushes (%0d refused at full) and %0d pops (%0d on empty),",
             n_push, n_drop, n_pop, n_pop_empty);
    $display("peak fill %0d of %0d entries, %0d result beats checked.",
             peak_fill, CAP, results_seen);
    if (err_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/hmq_pkg.sv
rtl/hmq_ctrl.sv
rtl/hmq_dpath.sv
rtl/binary_max_heap_queue.sv
bench/testbench.sv
